// ===== design/sqct_pkg.sv =====
package sqct_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int SCALE_W = 16;
  localparam int ANGLE_W = 16;

  // Datapath widths
  localparam int REL_W      = COORD_W + 1;        // corner relative to pivot
  localparam int PROD_W     = REL_W + SCALE_W;    // corner times scale
  localparam int SCALE_FRAC = 8;
  localparam int SCL_W      = PROD_W - SCALE_FRAC; // scaled corner
  localparam int TRIG_W     = 17;                 // Q1.15 with room for +1.0
  localparam int TRIG_FRAC  = 15;
  localparam int ROT_PROD_W = TRIG_W + SCL_W;     // trig times scaled corner
  localparam int ROT_W      = ROT_PROD_W - TRIG_FRAC;
  localparam int SUM_W      = ROT_W + 1;          // rotated corner plus origin

  // CORDIC
  localparam int CORDIC_W         = 33;
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CORDIC_LAT       = CORDIC_STAGES + 2;
  localparam int PIPE_DEPTH       = CORDIC_LAT + 3;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE  = 33'sd1073741824;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [CORDIC_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
  };

  localparam logic signed [COORD_W-1:0] OUT_MAX = 24'sd8388607;
  localparam logic signed [COORD_W-1:0] OUT_MIN = -24'sd8388608;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] size_w;
    logic signed [COORD_W-1:0] size_h;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic [ANGLE_W-1:0]        angle;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] corner1_x;
    logic signed [COORD_W-1:0] corner1_y;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
    logic signed [COORD_W-1:0] corner3_x;
    logic signed [COORD_W-1:0] corner3_y;
    logic signed [COORD_W-1:0] corner4_x;
    logic signed [COORD_W-1:0] corner4_y;
  } result_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_q15;
    logic signed [TRIG_W-1:0] sin_q15;
  } trig_t;

endpackage

// ===== design/sqct_cordic.sv =====
module sqct_cordic import sqct_pkg::*; (
  input  logic               clk,
  input  logic [ANGLE_W-1:0] angle,
  output trig_t              trig
);

  localparam int REM_W   = ANGLE_W - 2;
  localparam int Z_SHIFT = 32 - ANGLE_W;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 33'sd16384;
  localparam logic signed [CORDIC_W-1:0] TRIG_MAX   = 33'sd32768;
  localparam logic signed [CORDIC_W-1:0] TRIG_MIN   = -33'sd32768;

  typedef struct packed {
    logic [CORDIC_W-1:0] x;
    logic [CORDIC_W-1:0] y;
    logic [CORDIC_W-1:0] z;
    logic [1:0]          quad;
    logic                rem_zero;
  } cvec_t;

  // One micro-rotation toward zero residual angle
  function automatic cvec_t rotate_step(input cvec_t v, input int step);
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    cvec_t r;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    dx = y >>> step;
    dy = x >>> step;
    r  = v;
    if (!z[CORDIC_W-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - CORDIC_ATAN[step];
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + CORDIC_ATAN[step];
    end
    return r;
  endfunction

  // Round Q2.30 to Q1.15 half up, clamp to plus or minus one
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + ROUND_HALF) >>> TRIG_FRAC;
    if (r > TRIG_MAX) begin
      r = TRIG_MAX;
    end else if (r < TRIG_MIN) begin
      r = TRIG_MIN;
    end
    return TRIG_W'(r);
  endfunction

  cvec_t stage [CORDIC_STAGES+1];

  // Load the start vector from the angle within its quadrant
  always_ff @(posedge clk) begin
    stage[0].x        <= CORDIC_GAIN;
    stage[0].y        <= '0;
    stage[0].z        <= CORDIC_W'({angle[REM_W-1:0], {Z_SHIFT{1'b0}}});
    stage[0].quad     <= angle[ANGLE_W-1:REM_W];
    stage[0].rem_zero <= (angle[REM_W-1:0] == '0);
  end

  // Two micro-rotations per register stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cvec_t nxt;

    always_comb begin
      nxt = stage[g];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        nxt = rotate_step(nxt, g * CORDIC_PER_STAGE + k);
      end
    end

    always_ff @(posedge clk) begin
      stage[g+1] <= nxt;
    end
  end

  // Apply the quadrant exactly, substitute the exact vector on quadrant edges
  logic signed [CORDIC_W-1:0] fx;
  logic signed [CORDIC_W-1:0] fy;
  logic signed [CORDIC_W-1:0] cos_full;
  logic signed [CORDIC_W-1:0] sin_full;

  always_comb begin
    fx = stage[CORDIC_STAGES].rem_zero ? CORDIC_ONE : stage[CORDIC_STAGES].x;
    fy = stage[CORDIC_STAGES].rem_zero ? '0 : stage[CORDIC_STAGES].y;
    unique case (stage[CORDIC_STAGES].quad)
      QUAD_0: begin
        cos_full = fx;
        sin_full = fy;
      end
      QUAD_1: begin
        cos_full = -fy;
        sin_full = fx;
      end
      QUAD_2: begin
        cos_full = -fx;
        sin_full = -fy;
      end
      QUAD_3: begin
        cos_full = fy;
        sin_full = -fx;
      end
      default: begin
        cos_full = fx;
        sin_full = fy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    trig.cos_q15 <= to_q15(cos_full);
    trig.sin_q15 <= to_q15(sin_full);
  end

endmodule

// ===== design/sprite_quad_corner_transform.sv =====
// Sprite quad corner transform.
//
// Input channel: drive one sprite description on item and pulse start. A beat
// is taken at every rising edge with start high and busy low; busy is never
// raised, so a new sprite may enter on every clock.
// Output channel: result carries the four corners (bottom left first, then
// clockwise) and done is high for exactly one cycle per sprite. The
// receiver has to take the beat in that cycle; there is no backpressure.
//
// Depth: 13 register levels; done leaves the last one together with result.
// Throughput: one sprite per clock. The depth is set by the 16-step sine and
// cosine CORDIC, two micro-rotations per stage, in series with the two
// product and sum stages of the rotation, then the origin add and saturation.
//
// Reset (rst, synchronous) clears the valid bits of all levels, so beats in
// flight are dropped and no done is issued for them. Data registers keep
// whatever they hold.
module sprite_quad_corner_transform import sqct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int DLY_N = CORDIC_LAT - 2;

  localparam logic signed [PROD_W-1:0]     SCALE_HALF = 41'sd128;
  localparam logic signed [ROT_PROD_W-1:0] ROT_HALF   = 50'sd16384;

  typedef struct packed {
    logic signed [SCL_W-1:0] fx;
    logic signed [SCL_W-1:0] fx2;
    logic signed [SCL_W-1:0] fy;
    logic signed [SCL_W-1:0] fy2;
    logic signed [REL_W-1:0] wox;
    logic signed [REL_W-1:0] woy;
    logic                    zero;
  } scaled_t;

  function automatic logic signed [SCL_W-1:0] scale_round(input logic signed [PROD_W-1:0] p);
    return SCL_W'((p + SCALE_HALF) >>> SCALE_FRAC);
  endfunction

  function automatic logic signed [ROT_W-1:0] rot_round(input logic signed [ROT_PROD_W-1:0] s);
    return ROT_W'((s + ROT_HALF) >>> TRIG_FRAC);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [SUM_W-1:0] t);
    logic signed [COORD_W-1:0] r;
    if (t > SUM_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (t < SUM_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = COORD_W'(t);
    end
    return r;
  endfunction

  // The pipeline never refuses a beat
  assign busy = 1'b0;

  // Valid bits, one per register level
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Sine and cosine
  trig_t trig;

  sqct_cordic u_cordic (
    .clk   (clk),
    .angle (item.angle),
    .trig  (trig)
  );

  // Level 1: corners relative to the pivot, world origin
  logic signed [REL_W-1:0]   rx0;
  logic signed [REL_W-1:0]   rx1;
  logic signed [REL_W-1:0]   ry0;
  logic signed [REL_W-1:0]   ry1;
  logic signed [REL_W-1:0]   wox1;
  logic signed [REL_W-1:0]   woy1;
  logic signed [SCALE_W-1:0] sx1;
  logic signed [SCALE_W-1:0] sy1;
  logic                      zero1;

  always_ff @(posedge clk) begin
    rx0   <= -REL_W'(item.pivot_x);
    rx1   <= REL_W'(item.size_w) - REL_W'(item.pivot_x);
    ry0   <= -REL_W'(item.pivot_y);
    ry1   <= REL_W'(item.size_h) - REL_W'(item.pivot_y);
    wox1  <= REL_W'(item.pos_x) + REL_W'(item.pivot_x);
    woy1  <= REL_W'(item.pos_y) + REL_W'(item.pivot_y);
    sx1   <= item.scale_x;
    sy1   <= item.scale_y;
    zero1 <= (item.angle == '0);
  end

  // Level 2: scale products
  logic signed [PROD_W-1:0] px0;
  logic signed [PROD_W-1:0] px1;
  logic signed [PROD_W-1:0] py0;
  logic signed [PROD_W-1:0] py1;
  logic signed [REL_W-1:0]  wox2;
  logic signed [REL_W-1:0]  woy2;
  logic                     zero2;

  always_ff @(posedge clk) begin
    px0   <= PROD_W'(rx0) * PROD_W'(sx1);
    px1   <= PROD_W'(rx1) * PROD_W'(sx1);
    py0   <= PROD_W'(ry0) * PROD_W'(sy1);
    py1   <= PROD_W'(ry1) * PROD_W'(sy1);
    wox2  <= wox1;
    woy2  <= woy1;
    zero2 <= zero1;
  end

  // Level 3 to 10: round the scaled corners, then hold them until trig is ready
  scaled_t dly [DLY_N];

  always_ff @(posedge clk) begin
    dly[0].fx   <= scale_round(px0);
    dly[0].fx2  <= scale_round(px1);
    dly[0].fy   <= scale_round(py0);
    dly[0].fy2  <= scale_round(py1);
    dly[0].wox  <= wox2;
    dly[0].woy  <= woy2;
    dly[0].zero <= zero2;
    for (int i = 1; i < DLY_N; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  // Level 11: rotation products
  logic signed [ROT_PROD_W-1:0] pcx [2];
  logic signed [ROT_PROD_W-1:0] psx [2];
  logic signed [ROT_PROD_W-1:0] pcy [2];
  logic signed [ROT_PROD_W-1:0] psy [2];
  scaled_t                      sc11;

  always_ff @(posedge clk) begin
    pcx[0] <= ROT_PROD_W'(trig.cos_q15) * ROT_PROD_W'(dly[DLY_N-1].fx);
    pcx[1] <= ROT_PROD_W'(trig.cos_q15) * ROT_PROD_W'(dly[DLY_N-1].fx2);
    psx[0] <= ROT_PROD_W'(trig.sin_q15) * ROT_PROD_W'(dly[DLY_N-1].fx);
    psx[1] <= ROT_PROD_W'(trig.sin_q15) * ROT_PROD_W'(dly[DLY_N-1].fx2);
    pcy[0] <= ROT_PROD_W'(trig.cos_q15) * ROT_PROD_W'(dly[DLY_N-1].fy);
    pcy[1] <= ROT_PROD_W'(trig.cos_q15) * ROT_PROD_W'(dly[DLY_N-1].fy2);
    psy[0] <= ROT_PROD_W'(trig.sin_q15) * ROT_PROD_W'(dly[DLY_N-1].fy);
    psy[1] <= ROT_PROD_W'(trig.sin_q15) * ROT_PROD_W'(dly[DLY_N-1].fy2);
    sc11   <= dly[DLY_N-1];
  end

  // Level 12: combine and round, or pass scaled corners through at zero angle
  logic signed [ROT_W-1:0] cx [4];
  logic signed [ROT_W-1:0] cy [4];
  logic signed [REL_W-1:0] wox12;
  logic signed [REL_W-1:0] woy12;

  always_ff @(posedge clk) begin
    if (sc11.zero) begin
      cx[0] <= ROT_W'(sc11.fx);
      cy[0] <= ROT_W'(sc11.fy);
      cx[1] <= ROT_W'(sc11.fx);
      cy[1] <= ROT_W'(sc11.fy2);
      cx[2] <= ROT_W'(sc11.fx2);
      cy[2] <= ROT_W'(sc11.fy2);
      cx[3] <= ROT_W'(sc11.fx2);
      cy[3] <= ROT_W'(sc11.fy);
    end else begin
      cx[0] <= rot_round(pcx[0] - psy[0]);
      cy[0] <= rot_round(psx[0] + pcy[0]);
      cx[1] <= rot_round(pcx[0] - psy[1]);
      cy[1] <= rot_round(psx[0] + pcy[1]);
      cx[2] <= rot_round(pcx[1] - psy[1]);
      cy[2] <= rot_round(psx[1] + pcy[1]);
      cx[3] <= rot_round(pcx[1] - psy[0]);
      cy[3] <= rot_round(psx[1] + pcy[0]);
    end
    wox12 <= sc11.wox;
    woy12 <= sc11.woy;
  end

  // Level 13: add the world origin and saturate
  always_ff @(posedge clk) begin
    result.corner1_x <= sat24(SUM_W'(cx[0]) + SUM_W'(wox12));
    result.corner1_y <= sat24(SUM_W'(cy[0]) + SUM_W'(woy12));
    result.corner2_x <= sat24(SUM_W'(cx[1]) + SUM_W'(wox12));
    result.corner2_y <= sat24(SUM_W'(cy[1]) + SUM_W'(woy12));
    result.corner3_x <= sat24(SUM_W'(cx[2]) + SUM_W'(wox12));
    result.corner3_y <= sat24(SUM_W'(cy[2]) + SUM_W'(woy12));
    result.corner4_x <= sat24(SUM_W'(cx[3]) + SUM_W'(wox12));
    result.corner4_y <= sat24(SUM_W'(cy[3]) + SUM_W'(woy12));
  end

  // Every done beat goes back to an accepted start, outside reset
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, PIPE_DEPTH))
    else $error("done without a matching start");

  // Sine and cosine stay within plus or minus one
  a_trig_clamped: assert property (@(posedge clk) disable iff (rst)
    vld[CORDIC_LAT-1] |-> (trig.cos_q15 <= 32768 && trig.cos_q15 >= -32768 &&
                           trig.sin_q15 <= 32768 && trig.sin_q15 >= -32768))
    else $error("trig value out of range");

  // On a quadrant edge exactly one of sine and cosine is zero
  a_quadrant_exact: assert property (@(posedge clk) disable iff (rst)
    $past(start && item.angle[ANGLE_W-3:0] == '0, CORDIC_LAT) |->
      ((trig.cos_q15 == '0) != (trig.sin_q15 == '0)))
    else $error("quadrant angle not exact");

endmodule
